[rtl/core/crc20ws_pkg.sv]
// Package for the CRC-20 word stream block: CRC width, polynomial, seed,
// the single-bit shift step and the control struct shared between stages.
// No dependencies.
`timescale 1ns / 1ps

package crc20ws_pkg;

  localparam int CRC_BITS = 20;
  // tdata width on the result side: CRC padded up to whole bytes
  localparam int OUT_TDATA_W = ((CRC_BITS + 7) / 8) * 8;

  typedef logic [CRC_BITS-1:0] crc_t;

  localparam crc_t CRC_POLY = 20'hC1ACF;
  localparam crc_t CRC_INIT = 20'hFFFFF;
  localparam crc_t CRC_TOP  = 20'h80000;

  // Control flags of the item held in the input register
  typedef struct packed {
    logic valid;
    logic last;
  } crc20ws_ctl_t;

  // One augmented MSB-first step: shift left, take the bit in at the bottom,
  // fold the polynomial in when the old top bit was set.
  function automatic crc_t crc_shift(crc_t r, logic b);
    logic fb;
    crc_t n;
    fb = r[CRC_BITS-1];
    n  = {r[CRC_BITS-2:0], b};
    if (fb) begin
      n = n ^ CRC_POLY;
    end
    return n;
  endfunction

  // Indirect form of the initial value: run the shift backwards CRC_BITS times.
  function automatic crc_t crc_indirect_init();
    crc_t r;
    r = CRC_INIT;
    for (int n = 0; n < CRC_BITS; n++) begin
      if (r[0]) begin
        r = (r >> 1) ^ (CRC_TOP | (CRC_POLY >> 1));
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

  localparam crc_t CRC_SEED = crc_indirect_init();

endpackage

[rtl/core/crc20ws_in_stage.sv]
// Input register of the CRC-20 word stream block: holds one word and its
// last flag until the engine takes it. Depends on crc20ws_pkg.
`timescale 1ns / 1ps

module crc20ws_in_stage #(
  parameter int WORD_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [WORD_BITS-1:0]      s_word,
  input  logic                      s_last,
  input  logic                      advance,
  output logic [WORD_BITS-1:0]      word,
  output crc20ws_pkg::crc20ws_ctl_t ctl
);
  import crc20ws_pkg::*;

  logic valid;
  logic valid_next;
  logic last;
  logic accept;

  // free when empty or when the held item leaves this cycle
  assign s_tready = !valid || advance;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    valid_next = valid;
    if (accept) begin
      valid_next = 1'b1;
    end else if (advance) begin
      valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      word <= s_word;
      last <= s_last;
    end
  end

  assign ctl.valid = valid;
  assign ctl.last  = last;

endmodule

[rtl/core/crc20ws_engine.sv]
// CRC engine: absorbs the held word into the CRC register and, for a last
// word, appends the zero flush and reseeds. Depends on crc20ws_pkg.
`timescale 1ns / 1ps

module crc20ws_engine #(
  parameter int WORD_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [WORD_BITS-1:0]      word,
  input  crc20ws_pkg::crc20ws_ctl_t ctl,
  input  logic                      out_free,
  output logic                      advance,
  output logic                      result_valid,
  output crc20ws_pkg::crc_t         result
);
  import crc20ws_pkg::*;

  crc_t crc_register;
  crc_t crc_register_next;
  crc_t absorbed;
  crc_t flushed;

  // a last word needs room in the output register
  assign advance      = ctl.valid && (!ctl.last || out_free);
  assign result_valid = advance && ctl.last;

  // Linear in data and state: both loops collapse into XOR trees.
  always_comb begin
    absorbed = crc_register;
    for (int k = WORD_BITS - 1; k >= 0; k--) begin
      absorbed = crc_shift(absorbed, word[k]);
    end
    flushed = absorbed;
    for (int k = 0; k < CRC_BITS; k++) begin
      flushed = crc_shift(flushed, 1'b0);
    end
  end

  assign result = flushed;

  always_comb begin
    crc_register_next = crc_register;
    if (advance) begin
      crc_register_next = ctl.last ? CRC_SEED : absorbed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_register <= CRC_SEED;
    end else begin
      crc_register <= crc_register_next;
    end
  end

endmodule

[rtl/core/crc20ws_out_stage.sv]
// Output register of the CRC-20 word stream block: holds a finished CRC
// until the downstream side takes it. Depends on crc20ws_pkg.
`timescale 1ns / 1ps

module crc20ws_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  crc20ws_pkg::crc_t value,
  output logic              out_free,
  output logic              m_tvalid,
  input  logic              m_tready,
  output crc20ws_pkg::crc_t m_crc
);
  import crc20ws_pkg::*;

  logic valid;
  logic valid_next;

  assign out_free = !valid || m_tready;

  always_comb begin
    valid_next = valid;
    if (load) begin
      valid_next = 1'b1;
    end else if (m_tready) begin
      valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_crc <= value;
    end
  end

  assign m_tvalid = valid;

endmodule

[rtl/core/crc20_word_stream_top.sv]
// Top level of the CRC-20 word stream block (polynomial 0xC1ACF, augmented,
// MSB first). Depends on crc20ws_pkg, crc20ws_in_stage, crc20ws_engine,
// crc20ws_out_stage.
//
//   channel   dir   tdata                          tlast
//   s_axis    in    data_word[WORD_BITS-1:0]       last_word
//   m_axis    out   crc_value[19:0], zero padded   -
//
// Cycles: one word per cycle sustained, except for the stalls below. A word
// sits in the input register, where the word absorb updates the CRC register
// and the 20-bit flush forms the CRC (one XOR tree each); a last word loads
// its CRC into the output register and reseeds the CRC register.
// Reset: clears both stage valids and loads the CRC register with the seed.
// Stalls: the input register holds a last word while the output register
// is still full and not being taken; other words never wait.
`timescale 1ns / 1ps

module crc20_word_stream_top #(
  parameter int WORD_BITS = 32
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // data_word from bit 0, zero padding to whole bytes above
  input  logic [((WORD_BITS + 7) / 8) * 8 - 1:0] s_tdata,
  input  logic                                   s_tlast,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // crc_value from bit 0, zero padding to whole bytes above
  output logic [crc20ws_pkg::OUT_TDATA_W-1:0]    m_tdata
);
  import crc20ws_pkg::*;

  logic [WORD_BITS-1:0] word;
  crc20ws_ctl_t         ctl;
  logic                 advance;
  logic                 result_valid;
  crc_t                 result;
  logic                 out_free;
  crc_t                 m_crc;

  // Hold the incoming transaction; padding bits of tdata are dropped here
  crc20ws_in_stage #(
    .WORD_BITS (WORD_BITS)
  ) u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_word   (s_tdata[WORD_BITS-1:0]),
    .s_last   (s_tlast),
    .advance  (advance),
    .word     (word),
    .ctl      (ctl)
  );

  // Advance the CRC register by one word, flush and reseed on a last word
  crc20ws_engine #(
    .WORD_BITS (WORD_BITS)
  ) u_engine (
    .clk          (clk),
    .rst          (rst),
    .word         (word),
    .ctl          (ctl),
    .out_free     (out_free),
    .advance      (advance),
    .result_valid (result_valid),
    .result       (result)
  );

  // Hold the finished CRC until the downstream transaction completes
  crc20ws_out_stage u_out_stage (
    .clk      (clk),
    .rst      (rst),
    .load     (result_valid),
    .value    (result),
    .out_free (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_crc    (m_crc)
  );

  assign m_tdata = {{(OUT_TDATA_W - CRC_BITS){1'b0}}, m_crc};

endmodule

[dv/tb_top.sv]
// Self-checking testbench for crc20_word_stream_top: directed word table, then random
// messages, with an in-bench CRC-20 predictor checking every result transaction.
// Depends on crc20ws_pkg and the RTL under rtl/core.
`timescale 1ns / 1ps

module tb_top;
  import crc20ws_pkg::*;

  localparam int WORD_W = 32;
  localparam int RANDOM_ITEMS = 1250;
  localparam int MAX_SHOWN = 10;

  // One row of the directed table. Where known is set the CRC is typed in and
  // stands in place of the predictor; the predictor still advances on the word.
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              last;
    logic              known;
    crc_t              crc;
  } word_row_t;

  // Corners first: the all-zero and all-ones words, single set bits at either end,
  // one-word messages, multi-word messages and long runs of identical words.
  // A message whose first 20 bits are all ones cancels the seed exactly, so with
  // the rest of the message zero the register stays clear through the flush.
  localparam int N_ROWS = 22;
  localparam word_row_t DIRECTED_ROWS [N_ROWS] = '{
    '{32'h0000_0000, 1'b1, 1'b0, 20'h0},
    '{32'hFFFF_FFFF, 1'b1, 1'b0, 20'h0},
    '{32'hFFFF_F000, 1'b1, 1'b1, 20'h00000},
    '{32'hFFFF_F000, 1'b0, 1'b0, 20'h0},
    '{32'h0000_0000, 1'b1, 1'b1, 20'h00000},
    '{32'h8000_0000, 1'b1, 1'b0, 20'h0},
    '{32'h0000_0001, 1'b1, 1'b0, 20'h0},
    '{32'hAAAA_AAAA, 1'b0, 1'b0, 20'h0},
    '{32'h5555_5555, 1'b1, 1'b0, 20'h0},
    '{32'h1234_5678, 1'b0, 1'b0, 20'h0},
    '{32'h9ABC_DEF0, 1'b0, 1'b0, 20'h0},
    '{32'h0F0F_0F0F, 1'b1, 1'b0, 20'h0},
    '{32'hFFFF_FFFF, 1'b0, 1'b0, 20'h0},
    '{32'hFFFF_FFFF, 1'b0, 1'b0, 20'h0},
    '{32'hFFFF_FFFF, 1'b1, 1'b0, 20'h0},
    '{32'h0000_0000, 1'b0, 1'b0, 20'h0},
    '{32'h0000_0000, 1'b0, 1'b0, 20'h0},
    '{32'h0000_0000, 1'b0, 1'b0, 20'h0},
    '{32'h0000_0000, 1'b1, 1'b0, 20'h0},
    '{32'hDEAD_BEEF, 1'b1, 1'b0, 20'h0},
    '{32'h000F_FFFF, 1'b1, 1'b0, 20'h0},
    '{32'h7FFF_FFFE, 1'b1, 1'b0, 20'h0}
  };

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [WORD_W-1:0]      s_tdata = '0;   // data_word[31:0]
  logic                   s_tlast = 1'b0; // last_word
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;        // crc_value[19:0], zero padding above

  crc_t crc_state;            // predictor's copy of the CRC register
  crc_t crc_expect_q[$];      // CRCs owed by the block, oldest first
  crc_t want_crc;
  int   fail_count = 0;

  crc20_word_stream_top #(
    .WORD_BITS(WORD_W)
  ) DUT (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // One augmented MSB-first step: bit in at the bottom, polynomial folded in
  // whenever a set bit falls off the top.
  function automatic crc_t crc_step(crc_t r, logic b);
    crc_t shifted;
    shifted = {r[CRC_BITS-2:0], b};
    return r[CRC_BITS-1] ? (shifted ^ CRC_POLY) : shifted;
  endfunction

  // Seed: undo 20 zero-bit steps starting from all ones. An odd low bit can only
  // come from a polynomial fold, so strip the polynomial and restore the top bit.
  function automatic crc_t crc_seed();
    crc_t r;
    r = CRC_INIT;
    for (int i = 0; i < CRC_BITS; i++) begin
      r = r[0] ? (((r ^ CRC_POLY) >> 1) | CRC_TOP) : (r >> 1);
    end
    return r;
  endfunction

  // Advance the predictor by one accepted word; a last word adds the flush,
  // queues the CRC and reloads the seed.
  task automatic absorb_word(input logic [WORD_W-1:0] w, input logic last,
                             input logic known, input crc_t known_crc);
    crc_t r;
    r = crc_state;
    for (int k = WORD_W - 1; k >= 0; k--) begin
      r = crc_step(r, w[k]);
    end
    if (last) begin
      for (int k = 0; k < CRC_BITS; k++) begin
        r = crc_step(r, 1'b0);
      end
      crc_expect_q.push_back(known ? known_crc : r);
      crc_state = crc_seed();
    end else begin
      crc_state = r;
    end
  endtask

  // Idle length: mostly none or short, now and then a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      return 0;
    end else if (roll < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(6, 30);
  endfunction

  // Mostly full-entropy words, with a share of all-zero, all-ones and
  // single-bit patterns to keep the register corners busy
  function automatic logic [WORD_W-1:0] pick_word();
    logic [WORD_W-1:0] one_bit;
    one_bit = 32'h1 << $urandom_range(0, WORD_W - 1);
    case ($urandom_range(0, 9))
      0: begin
        return '0;
      end
      1: begin
        return '1;
      end
      2: begin
        return one_bit;
      end
      3: begin
        return ~one_bit;
      end
      default: begin
        return $urandom;
      end
    endcase
  endfunction

  // Present one word and hold it until the transaction completes. Each step
  // sees a single assignment to s_tvalid: either a drop for the gap or a raise.
  task automatic send_word(input logic [WORD_W-1:0] w, input logic last,
                           input logic no_gap);
    int gap;
    gap = no_gap ? 0 : pick_gap();
    repeat (gap) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= w;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) begin
      @(posedge clk);
    end
  endtask

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_SHOWN) begin
      $display("%t: %s", $realtime, msg);
    end
  endtask

  // Result side: ready for a random stretch, then stall for a random gap.
  // Occasionally hold ready for a long run so back-to-back results flow.
  initial begin
    int hold;
    int stall;
    forever begin
      hold = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 24);
      m_tready <= 1'b1;
      repeat (hold) @(posedge clk);
      stall = pick_gap();
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // Compare every result transaction with the oldest owed CRC; padding must be zero
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (crc_expect_q.size() == 0) begin
        note_failure($sformatf("unexpected result transaction, tdata %06h", m_tdata));
      end else begin
        want_crc = crc_expect_q.pop_front();
        if (m_tdata !== OUT_TDATA_W'(want_crc)) begin
          note_failure($sformatf("CRC mismatch: expected %06h, got %06h",
                                 OUT_TDATA_W'(want_crc), m_tdata));
        end
      end
    end
  end

  // Stimulus: reset, directed table, then random messages
  initial begin
    int                sent;
    int                msg_len;
    logic              burst;
    logic [WORD_W-1:0] w;
    logic              last;

    crc_state = crc_seed();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table
    for (int i = 0; i < N_ROWS; i++) begin
      send_word(DIRECTED_ROWS[i].word, DIRECTED_ROWS[i].last, 1'b0);
      absorb_word(DIRECTED_ROWS[i].word, DIRECTED_ROWS[i].last,
                  DIRECTED_ROWS[i].known, DIRECTED_ROWS[i].crc);
    end

    // Random messages: mostly short, some medium, a few long; a quarter of them
    // go out as one unbroken burst
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 19))
        0: begin
          msg_len = $urandom_range(17, 64);
        end
        1, 2, 3, 4, 5: begin
          msg_len = $urandom_range(5, 16);
        end
        default: begin
          msg_len = $urandom_range(1, 4);
        end
      endcase
      burst = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < msg_len; k++) begin
        w    = pick_word();
        last = (k == msg_len - 1);
        send_word(w, last, burst && (k != 0));
        absorb_word(w, last, 1'b0, '0);
        sent++;
      end
    end
    s_tvalid <= 1'b0;

    // Drain: wait for every owed CRC, then idle to catch anything stray
    while (crc_expect_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);

    if (fail_count == 0 && crc_expect_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of this stimulus
  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
